// ----- src/psu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psu_pkg: shared types and constants of the PNG scanline unfilter
// Filter codes, configuration register indexes and the queue entry that
// passes from the classifying front end to the reconstruction back end.
// ----------------------------------------------------------------------------
package psu_pkg;

  // Default line length limit in pixels
  localparam int unsigned MAX_ROW_PIXELS_DEF = 4096;

  // Configuration port layout
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned ROW_WIDTH_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_ALPHA = CFG_IDX_W'(1);

  // Alpha sample of an RGB pixel
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // Byte lanes of the last component of a pixel
  localparam logic [1:0] LANE_LAST_RGB  = 2'd2;
  localparam logic [1:0] LANE_LAST_RGBA = 2'd3;

  // Scanline filter types
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } psu_filter_e;

  // Highest valid filter type as a byte
  localparam logic [7:0] FILT_MAX_BYTE = 8'd4;

  // What the back end does with a queue entry
  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,  // filter byte: clear left and above-left history
    KIND_SAMPLE = 2'd1,  // filtered sample to reconstruct
    KIND_ERROR  = 2'd2   // unknown filter type: emit error beat
  } psu_kind_e;

  // Classified item, column address travels beside it
  typedef struct packed {
    psu_kind_e   kind;
    logic [7:0]  data;       // filtered sample
    logic [1:0]  lane;       // component index within the pixel
    logic        last;       // last byte of the row
    logic        emit;       // completes a pixel
    logic        rgba;       // four bytes per pixel
    logic        first_row;  // no row above
    psu_filter_e filter;
  } psu_entry_t;

endpackage : psu_pkg
`default_nettype wire

// ----- src/png_scanline_unfilter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// png_scanline_unfilter: PNG filter reconstruction for 8-bit RGB / RGBA
// Takes the decompressed scanline stream one byte per beat and emits one
// RGBA pixel beat per completed pixel, or an error beat for a bad filter.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+------------------------------------
//   s_axis  | in  | tvalid / tready    | tdata: data_byte; tuser: start_of_image
//   m_axis  | out | tvalid / tready    | tdata: red,green,blue,alpha; tlast: row_end;
//           |     |                    | tuser: bad_filter
//   cfg     | in  | valid / ready (=1) | index 0 row_width, 1 has_alpha
//
// One byte per cycle while the output is not stalled; the last byte of a pixel
// passes the queue, the line store read and reconstruction into the output
// register. The line store read for a column is issued as the entry leaves
// the queue. Reset clears all row state; the line store is not cleared.
// A stalled output holds the back end, the two-entry queue then fills and
// drops s_axis_tready.
// ----------------------------------------------------------------------------
module png_scanline_unfilter
  import psu_pkg::*;
#(
  parameter int unsigned MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // byte stream in
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  input  wire logic                  s_axis_tuser,   // [0] start_of_image
  // pixel stream out
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [31:0]           m_axis_tdata,   // red, green, blue, alpha
  output logic                       m_axis_tlast,   // row_end
  output logic                       m_axis_tuser    // [0] bad_filter
);

  localparam int unsigned COL_W = $clog2(MAX_ROW_PIXELS * 4);

  logic             q_full, q_empty, q_push, q_pop;
  psu_entry_t       push_entry, head_entry;
  logic [COL_W-1:0] push_col, head_col;

  // Classify incoming bytes
  psu_front #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_soi_i     (s_axis_tuser),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .push_entry_o (push_entry),
    .push_col_o   (push_col)
  );

  // Decouple front and back
  psu_queue #(
    .COL_W (COL_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .push_col_i   (push_col),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .empty_o      (q_empty),
    .head_entry_o (head_entry),
    .head_col_o   (head_col)
  );

  // Reconstruct samples and emit pixels
  psu_back #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_entry_i     (head_entry),
    .q_col_i       (head_col),
    .q_pop_o       (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_pixel_o   (m_axis_tdata),
    .out_row_end_o (m_axis_tlast),
    .out_bad_o     (m_axis_tuser)
  );

endmodule : png_scanline_unfilter
`default_nettype wire

// ----- src/psu_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psu_ram: generic simple dual-port RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module psu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : psu_ram
`default_nettype wire

// ----- src/psu_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psu_queue: two-entry queue between front and back end
// Holds classified entries with their line store column.
// ----------------------------------------------------------------------------
module psu_queue
  import psu_pkg::*;
#(
  parameter int unsigned COL_W = 14
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire psu_entry_t       push_entry_i,
  input  wire logic [COL_W-1:0] push_col_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output psu_entry_t            head_entry_o,
  output logic      [COL_W-1:0] head_col_o
);

  psu_entry_t       entry_q [2];
  logic [COL_W-1:0] col_q   [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o       = (count_q == 2'd2);
  assign empty_o      = (count_q == 2'd0);
  assign head_entry_o = entry_q[rd_ptr_q];
  assign head_col_o   = col_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_entry_i;
      col_q[wr_ptr_q]   <= push_col_i;
    end
  end

endmodule : psu_queue
`default_nettype wire

// ----- src/psu_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psu_front: byte classifier of the PNG scanline unfilter
// Holds configuration and row position, splits the stream into filter
// bytes and samples and pushes one entry per kept byte into the queue.
// ----------------------------------------------------------------------------
module psu_front
  import psu_pkg::*;
#(
  parameter int unsigned MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF,
  localparam int unsigned COL_W = $clog2(MAX_ROW_PIXELS * 4),
  localparam int unsigned RB_W  = $clog2(MAX_ROW_PIXELS * 4 + 1),
  localparam int unsigned PIX_W = $clog2(MAX_ROW_PIXELS + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [7:0]            in_byte_i,
  input  wire logic                  in_soi_i,
  // queue side
  input  wire logic                  q_full_i,
  output logic                       push_o,
  output psu_entry_t                 push_entry_o,
  output logic      [COL_W-1:0]      push_col_o
);

  logic [ROW_WIDTH_W-1:0] row_width_q;
  logic                   has_alpha_q;

  logic              await_q, await_d;
  logic              first_q, first_d;
  logic              err_q, err_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [1:0]        mod3_q, mod3_d;
  psu_filter_e       filt_q, filt_d;

  logic              fire;
  logic [PIX_W-1:0]  pix_w;
  logic [RB_W-1:0]   line_len;
  logic              e_await, e_first, e_err;
  logic [COL_W-1:0]  e_col;
  logic [1:0]        e_mod3;
  logic              last;
  logic [1:0]        lane, lane_last;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~q_full_i;
  assign fire        = in_valid_i & in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_W'(1);
      has_alpha_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_ROW_WIDTH) begin
        row_width_q <= cfg_data_i[ROW_WIDTH_W-1:0];
      end else if (cfg_index_i == CFG_HAS_ALPHA) begin
        has_alpha_q <= cfg_data_i[0];
      end
    end
  end

  // Clamp row width and scale to bytes
  always_comb begin
    priority if (row_width_q == '0) begin
      pix_w = PIX_W'(1);
    end else if (32'(row_width_q) > 32'(MAX_ROW_PIXELS)) begin
      pix_w = PIX_W'(MAX_ROW_PIXELS);
    end else begin
      pix_w = PIX_W'(row_width_q);
    end
    if (has_alpha_q) begin
      line_len = RB_W'(pix_w) << 2;
    end else begin
      line_len = (RB_W'(pix_w) << 1) + RB_W'(pix_w);
    end
  end

  // Classify one byte
  always_comb begin
    e_await = await_q;
    e_first = first_q;
    e_err   = err_q;
    e_col   = col_q;
    e_mod3  = mod3_q;
    // start of image restarts the row state
    if (in_soi_i) begin
      e_await = 1'b1;
      e_first = 1'b1;
      e_err   = 1'b0;
      e_col   = '0;
      e_mod3  = 2'd0;
    end

    lane_last = has_alpha_q ? LANE_LAST_RGBA : LANE_LAST_RGB;
    last      = ((RB_W'(e_col) + RB_W'(1)) >= line_len);
    if (last) begin
      lane = lane_last;
    end else if (has_alpha_q) begin
      lane = e_col[1:0];
    end else begin
      lane = e_mod3;
    end

    push_entry_o.kind      = KIND_SAMPLE;
    push_entry_o.data      = in_byte_i;
    push_entry_o.lane      = lane;
    push_entry_o.last      = last;
    push_entry_o.emit      = (lane == lane_last);
    push_entry_o.rgba      = has_alpha_q;
    push_entry_o.first_row = e_first;
    push_entry_o.filter    = filt_q;
    push_col_o             = e_col;

    push_o  = 1'b0;
    await_d = await_q;
    first_d = first_q;
    err_d   = err_q;
    col_d   = col_q;
    mod3_d  = mod3_q;
    filt_d  = filt_q;

    if (fire) begin
      await_d = e_await;
      first_d = e_first;
      err_d   = e_err;
      col_d   = e_col;
      mod3_d  = e_mod3;
      priority if (e_err) begin
        // drop until start of image
      end else if (e_await) begin
        push_o = 1'b1;
        col_d  = '0;
        mod3_d = 2'd0;
        if (in_byte_i > FILT_MAX_BYTE) begin
          push_entry_o.kind = KIND_ERROR;
          err_d             = 1'b1;
        end else begin
          push_entry_o.kind = KIND_CLEAR;
          filt_d            = psu_filter_e'(in_byte_i[2:0]);
          await_d           = 1'b0;
        end
      end else begin
        push_o = 1'b1;
        if (last) begin
          col_d   = '0;
          mod3_d  = 2'd0;
          await_d = 1'b1;
          first_d = 1'b0;
        end else begin
          col_d  = e_col + COL_W'(1);
          mod3_d = (e_mod3 == 2'd2) ? 2'd0 : e_mod3 + 2'd1;
        end
      end
    end
  end

  // Row state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q <= 1'b1;
      first_q <= 1'b1;
      err_q   <= 1'b0;
      col_q   <= '0;
      mod3_q  <= 2'd0;
      filt_q  <= FILT_NONE;
    end else begin
      await_q <= await_d;
      first_q <= first_d;
      err_q   <= err_d;
      col_q   <= col_d;
      mod3_q  <= mod3_d;
      filt_q  <= filt_d;
    end
  end

endmodule : psu_front
`default_nettype wire

// ----- src/psu_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psu_back: sample reconstruction of the PNG scanline unfilter
// Pops entries, reads the byte above from the line store, applies the
// filter, writes the row back and gathers bytes into RGBA output beats.
// ----------------------------------------------------------------------------
module psu_back
  import psu_pkg::*;
#(
  parameter int unsigned MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF,
  localparam int unsigned DEPTH = MAX_ROW_PIXELS * 4,
  localparam int unsigned COL_W = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // queue side
  input  wire logic             q_empty_i,
  input  wire psu_entry_t       q_entry_i,
  input  wire logic [COL_W-1:0] q_col_i,
  output logic                  q_pop_o,
  // output stream
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [31:0]      out_pixel_o,
  output logic                  out_row_end_o,
  output logic                  out_bad_o
);

  psu_entry_t       ex_q;
  logic [COL_W-1:0] ex_col_q;
  logic             ex_valid_q;

  logic [31:0] left_q, left_d;
  logic [31:0] above_q, above_d;
  logic [23:0] gather_q, gather_d;

  logic        out_valid_q;
  logic [31:0] out_pixel_q, out_pixel_d;
  logic        out_row_end_q, out_row_end_d;
  logic        out_bad_q, out_bad_d;

  logic [7:0]  above_rd;
  logic [7:0]  a, b, c, pred, x;
  logic [8:0]  avg_sum;
  logic [9:0]  pa, pb, pc;
  logic        needs_out, commit, load_out, we;

  function automatic logic [9:0] abs_diff(input logic [9:0] p, input logic [9:0] q);
    logic [9:0] d;
    d = p - q;
    abs_diff = d[9] ? (~d + 10'd1) : d;
  endfunction

  // Line store, one byte per column of the previous row
  psu_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ex_col_q),
    .wdata_i (x),
    .re_i    (q_pop_o),
    .raddr_i (q_col_i),
    .rdata_o (above_rd)
  );

  // Handshake between execute register, queue and output register
  always_comb begin
    needs_out = (ex_q.kind == KIND_ERROR) || ((ex_q.kind == KIND_SAMPLE) && ex_q.emit);
    commit    = ex_valid_q && (!needs_out || !out_valid_q || out_ready_i);
    q_pop_o   = !q_empty_i && (!ex_valid_q || commit);
    load_out  = commit && needs_out;
    we        = commit && (ex_q.kind == KIND_SAMPLE);
  end

  // Predict and reconstruct the sample
  always_comb begin
    a       = left_q[8*ex_q.lane +: 8];
    b       = ex_q.first_row ? 8'd0 : above_rd;
    c       = ex_q.first_row ? 8'd0 : above_q[8*ex_q.lane +: 8];
    avg_sum = {1'b0, a} + {1'b0, b};
    // Paeth distances: |b-c|, |a-c|, |a+b-2c|
    pa      = abs_diff({2'b0, b}, {2'b0, c});
    pb      = abs_diff({2'b0, a}, {2'b0, c});
    pc      = abs_diff({2'b0, a} + {2'b0, b}, {1'b0, c, 1'b0});
    unique case (ex_q.filter)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: begin
        priority if (pa < pb && pa < pc) begin
          pred = a;
        end else if (pb < pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:    pred = 8'd0;
    endcase
    x = ex_q.data + pred;
  end

  // Update history and build the output beat
  always_comb begin
    left_d        = left_q;
    above_d       = above_q;
    gather_d      = gather_q;
    out_pixel_d   = out_pixel_q;
    out_row_end_d = out_row_end_q;
    out_bad_d     = out_bad_q;
    if (commit) begin
      unique case (ex_q.kind)
        KIND_CLEAR: begin
          left_d   = '0;
          above_d  = '0;
          gather_d = '0;
        end
        KIND_ERROR: begin
          left_d        = '0;
          above_d       = '0;
          gather_d      = '0;
          out_pixel_d   = '0;
          out_row_end_d = 1'b0;
          out_bad_d     = 1'b1;
        end
        KIND_SAMPLE: begin
          left_d[8*ex_q.lane +: 8]  = x;
          above_d[8*ex_q.lane +: 8] = b;
          if (ex_q.emit) begin
            gather_d = '0;
            if (ex_q.rgba) begin
              out_pixel_d = {x, gather_q};
            end else begin
              out_pixel_d = {ALPHA_OPAQUE, x, gather_q[15:0]};
            end
            out_row_end_d = ex_q.last;
            out_bad_d     = 1'b0;
          end else if (ex_q.lane != LANE_LAST_RGBA) begin
            gather_d[8*ex_q.lane[1:0] +: 8] = x;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      above_q     <= '0;
      gather_q    <= '0;
    end else begin
      if (q_pop_o) begin
        ex_valid_q <= 1'b1;
      end else if (commit) begin
        ex_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      left_q   <= left_d;
      above_q  <= above_d;
      gather_q <= gather_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ex_q     <= q_entry_i;
      ex_col_q <= q_col_i;
    end
    out_pixel_q   <= out_pixel_d;
    out_row_end_q <= out_row_end_d;
    out_bad_q     <= out_bad_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_pixel_o   = out_pixel_q;
  assign out_row_end_o = out_row_end_q;
  assign out_bad_o     = out_bad_q;

endmodule : psu_back
`default_nettype wire

// ----- dv/tb_png_scanline_unfilter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_png_scanline_unfilter: self-checking bench for the PNG scanline unfilter
// Drives filtered scanline bytes through the slave stream and predicts every
// pixel and error beat with a behavioral copy of the row reconstruction.
// A short table opens the run (reset settings, every filter, bad filter
// types), then random images follow at several widths and pixel formats.
// Those images include mid-row cuts of width or alpha and stray image starts.
// Both stream sides idle at random, except in the last part of the run.
// ----------------------------------------------------------------------------
module tb_png_scanline_unfilter;
  import psu_pkg::*;

  localparam int unsigned MAX_PIX       = MAX_ROW_PIXELS_DEF;
  localparam int unsigned STORE_BYTES   = MAX_PIX * 4;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned STALL_LIMIT   = 2000;

  typedef struct packed {
    logic       bad_filter;
    logic       row_end;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct {
    logic [7:0] din;
    logic       soi;
    bit         typed;  // expectation given in the table
    bit         gives;  // table row yields a beat
    pixel_t     px;
  } dir_step_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;  // [7:0] data_byte
  logic                  s_axis_tuser  = 1'b0;  // [0] start_of_image
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  logic                  m_axis_tlast;  // row_end
  logic                  m_axis_tuser;  // [0] bad_filter

  int unsigned src_idle_pct = 20;
  int unsigned rcv_idle_pct = 68;
  int unsigned beats_sent   = 0;
  int unsigned stall_cycles = 0;
  int unsigned fail_cnt     = 0;

  pixel_t    pending_px[$];
  dir_step_t dir_tab[$];

  // Predicted block state
  logic [ROW_WIDTH_W-1:0] cur_width = ROW_WIDTH_W'(1);
  logic                   cur_rgba  = 1'b0;
  logic [7:0]             prior_row [STORE_BYTES];
  logic [31:0]            left_px       = '0;
  logic [31:0]            above_left_px = '0;
  psu_filter_e            cur_filter    = FILT_NONE;
  int unsigned            col_pos       = 0;
  bit                     want_filter   = 1'b1;
  bit                     first_row     = 1'b1;
  bit                     err_locked    = 1'b0;
  logic [23:0]            gather        = '0;

  png_scanline_unfilter uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // Row width after clamping to the supported range
  function automatic int unsigned eff_width();
    if (cur_width == 0) return 1;
    if (32'(cur_width) > MAX_PIX) return MAX_PIX;
    return 32'(cur_width);
  endfunction

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, b, c);
    int ia, ib, ic, p, pa, pb, pc;
    ia = int'(a);
    ib = int'(b);
    ic = int'(c);
    p  = ia + ib - ic;
    pa = (p > ia) ? p - ia : ia - p;
    pb = (p > ib) ? p - ib : ib - p;
    pc = (p > ic) ? p - ic : ic - p;
    if (pa < pb && pa < pc) return a;
    if (pb < pc) return b;
    return c;
  endfunction

  // Reconstruct one accepted byte; returns 1 when it completes a beat
  function automatic bit unfilter_step(input logic [7:0] din, input logic soi,
                                       output pixel_t px);
    int unsigned bpp, line_len, col, k;
    logic [7:0]  a, b, c, pred, x;
    bit          last;
    px        = '0;
    bpp       = cur_rgba ? 4 : 3;
    line_len  = eff_width() * bpp;
    if (soi) begin
      err_locked  = 1'b0;
      first_row   = 1'b1;
      want_filter = 1'b1;
      col_pos     = 0;
    end
    if (err_locked) return 1'b0;

    // Filter byte: clear the row history, latch the filter or the error
    if (want_filter) begin
      col_pos       = 0;
      left_px       = '0;
      above_left_px = '0;
      gather        = '0;
      if (din > FILT_MAX_BYTE) begin
        err_locked    = 1'b1;
        px.bad_filter = 1'b1;
        return 1'b1;
      end
      cur_filter  = psu_filter_e'(din[2:0]);
      want_filter = 1'b0;
      return 1'b0;
    end

    col = (col_pos >= STORE_BYTES) ? STORE_BYTES - 1 : col_pos;
    last = (col + 1 >= line_len);
    k    = last ? bpp - 1 : col % bpp;
    a    = left_px[8*k +: 8];
    b    = first_row ? 8'h00 : prior_row[col];
    c    = first_row ? 8'h00 : above_left_px[8*k +: 8];
    case (cur_filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = 8'((int'(a) + int'(b)) >> 1);
      FILT_PAETH: pred = paeth_pick(a, b, c);
      default:    pred = 8'h00;
    endcase
    x = din + pred;

    prior_row[col]          = x;
    left_px[8*k +: 8]       = x;
    above_left_px[8*k +: 8] = b;

    // Hold partial pixel until its last component
    if (k + 1 < bpp) begin
      gather[8*k +: 8] = x;
      col_pos          = col + 1;
      return 1'b0;
    end

    px.red   = gather[7:0];
    px.green = gather[15:8];
    if (bpp == 4) begin
      px.blue  = gather[23:16];
      px.alpha = x;
    end else begin
      px.blue  = x;
      px.alpha = ALPHA_OPAQUE;
    end
    px.row_end = last;
    gather     = '0;
    if (last) begin
      col_pos     = 0;
      want_filter = 1'b1;
      first_row   = 1'b0;
    end else begin
      col_pos = col + 1;
    end
    return 1'b1;
  endfunction

  function automatic void add_step(input logic [7:0] din, input logic soi,
                                   input bit typed = 1'b0, input bit gives = 1'b0,
                                   input pixel_t px = '0);
    dir_step_t st;
    st.din   = din;
    st.soi   = soi;
    st.typed = typed;
    st.gives = gives;
    st.px    = px;
    dir_tab.push_back(st);
  endfunction

  // Offer one byte beat, predict its outcome once accepted
  task automatic send_byte(input logic [7:0] din, input logic soi,
                           input bit typed = 1'b0, input bit typed_gives = 1'b0,
                           input pixel_t typed_px = '0);
    pixel_t px;
    bit     gives;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= din;
    s_axis_tuser  <= soi;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    gives = unfilter_step(din, soi, px);
    if (typed) begin
      gives = typed_gives;
      px    = typed_px;
    end
    if (gives) pending_px.push_back(px);
    beats_sent++;
  endtask

  // Write a register once every beat is out and the pipeline has settled
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ROW_WIDTH: cur_width = val[ROW_WIDTH_W-1:0];
      CFG_HAS_ALPHA: cur_rgba  = val[0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] pick_filter();
    if ($urandom_range(99) < 4) return 8'($urandom_range(int'(FILT_MAX_BYTE) + 1, 255));
    return 8'($urandom_range(int'(FILT_NONE), int'(FILT_PAETH)));
  endfunction

  // Random settings, then a few images; settings change freely ahead of an image start and only shrink mid-row
  task automatic run_segment();
    logic [ROW_WIDTH_W-1:0] row_px;
    logic [CFG_DATA_W-1:0]  cfg_word;
    int unsigned            n_img, n_rows, line_len, cut;
    case ($urandom_range(19))
      0:       row_px = '0;
      1:       row_px = ROW_WIDTH_W'($urandom_range(13, 64));
      default: row_px = ROW_WIDTH_W'($urandom_range(1, 12));
    endcase
    cfg_word = CFG_DATA_W'($urandom);
    cfg_word[ROW_WIDTH_W-1:0] = row_px;
    write_reg(CFG_ROW_WIDTH, cfg_word);
    write_reg(CFG_HAS_ALPHA, CFG_DATA_W'($urandom));
    n_img = $urandom_range(1, 3);
    repeat (n_img) begin
      n_rows = $urandom_range(1, 4);
      for (int r = 0; r < n_rows; r++) begin
        line_len = eff_width() * (cur_rgba ? 4 : 3);
        send_byte(pick_filter(), r == 0);
        cut = ($urandom_range(99) < 6) ? $urandom_range(0, line_len - 1) : line_len;
        for (int i = 0; i < line_len; i++) begin
          // Shrink the row under way: drop alpha or narrow the width
          if (i == cut) begin
            cfg_word = CFG_DATA_W'($urandom);
            if (cur_rgba && $urandom_range(1)) begin
              cfg_word[0] = 1'b0;
              write_reg(CFG_HAS_ALPHA, cfg_word);
            end else begin
              cfg_word[ROW_WIDTH_W-1:0] = ROW_WIDTH_W'($urandom_range(0, eff_width()));
              write_reg(CFG_ROW_WIDTH, cfg_word);
            end
          end
          if ($urandom_range(199) == 0) send_byte(8'($urandom), 1'b1);
          send_byte(8'($urandom), 1'b0);
        end
      end
    end
  endtask

  // Receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Compare each output beat with the oldest prediction
  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    pixel_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_px.size() == 0) begin
        $error("unexpected output beat, tdata %08h", m_axis_tdata);
        fail_cnt++;
      end else begin
        want = pending_px.pop_front();
        check_field("red", want.red, m_axis_tdata[7:0]);
        check_field("green", want.green, m_axis_tdata[15:8]);
        check_field("blue", want.blue, m_axis_tdata[23:16]);
        check_field("alpha", want.alpha, m_axis_tdata[31:24]);
        check_field("row_end", 8'(want.row_end), 8'(m_axis_tlast));
        check_field("bad_filter", 8'(want.bad_filter), 8'(m_axis_tuser));
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    pixel_t bad_px;
    bad_px = '0;
    bad_px.bad_filter = 1'b1;

    // Reset settings: one RGB pixel per row
    add_step(8'(FILT_NONE), 1'b1);
    add_step(8'hFF, 1'b0, 1'b1);
    add_step(8'h00, 1'b0, 1'b1);
    add_step(8'h80, 1'b0, 1'b1, 1'b1, pixel_t'{bad_filter: 1'b0, row_end: 1'b1,
             alpha: ALPHA_OPAQUE, blue: 8'h80, green: 8'h00, red: 8'hFF});
    // Sub at the left edge passes the samples through
    add_step(8'(FILT_SUB), 1'b0);
    add_step(8'h01, 1'b0, 1'b1);
    add_step(8'h02, 1'b0, 1'b1);
    add_step(8'h03, 1'b0, 1'b1, 1'b1, pixel_t'{bad_filter: 1'b0, row_end: 1'b1,
             alpha: ALPHA_OPAQUE, blue: 8'h03, green: 8'h02, red: 8'h01});
    add_step(8'(FILT_UP), 1'b0);
    add_step(8'h00, 1'b0);
    add_step(8'h00, 1'b0);
    add_step(8'h00, 1'b0);
    add_step(8'(FILT_AVG), 1'b0);
    add_step(8'hFF, 1'b0);
    add_step(8'hFF, 1'b0);
    add_step(8'hFF, 1'b0);
    add_step(8'(FILT_PAETH), 1'b0);
    add_step(8'h80, 1'b0);
    add_step(8'h7F, 1'b0);
    add_step(8'h01, 1'b0);
    // Bad filter type, then dropped bytes, then a bad type on an image start
    add_step(FILT_MAX_BYTE + 8'd1, 1'b0, 1'b1, 1'b1, bad_px);
    add_step(8'h12, 1'b0, 1'b1);
    add_step(8'h34, 1'b0, 1'b1);
    add_step(8'hFF, 1'b1, 1'b1, 1'b1, bad_px);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].din, dir_tab[i].soi, dir_tab[i].typed, dir_tab[i].gives,
                dir_tab[i].px);
    end
    while (beats_sent < 580) run_segment();

    src_idle_pct = 68;
    rcv_idle_pct = 20;
    while (beats_sent < 1160) run_segment();

    src_idle_pct = 0;
    rcv_idle_pct = 0;
    while (beats_sent < 1700) run_segment();

    // Drain and let the pipeline go quiet
    s_axis_tvalid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- png_scanline_unfilter.f -----
src/psu_pkg.sv
src/psu_ram.sv
src/psu_queue.sv
src/psu_front.sv
src/psu_back.sv
src/png_scanline_unfilter.sv
dv/tb_png_scanline_unfilter.sv
